@@ rtl/core/bfd_pkg.sv @@
// Shared types and constants for the box filter downscaler.
`timescale 1ns / 1ps
`default_nettype none
package bfd_pkg;

   localparam int MAX_DIM      = 4096;
   localparam int MAX_CHANNELS = 4;
   localparam int POS_W        = $clog2(MAX_DIM);
   localparam int SZ_W         = POS_W + 1;
   localparam int PIX_W        = 8;
   localparam int SUM_W        = 32;
   localparam int AREA_W       = 2 * POS_W + 1;
   localparam int REM_W        = SUM_W + 1;
   localparam int QBITS        = 8;
   localparam int QB_W         = $clog2(QBITS);
   localparam int CC_W         = 3;

   localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [2:0] REG_CHANNELS   = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              take;
      logic              rd;
      logic              acc;
      logic              last;
      logic              wr;
      logic              div;
      logic [QB_W-1:0]   bit_idx;
      logic [POS_W-1:0]  addr;
      logic [AREA_W-1:0] area;
   } lane_ctl_type;

   typedef struct packed {
      logic             load;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             done;
   } out_meta_type;

   typedef struct packed {
      logic [SZ_W-1:0] src_width;
      logic [SZ_W-1:0] src_height;
      logic [SZ_W-1:0] dst_width;
      logic [SZ_W-1:0] dst_height;
      logic [CC_W-1:0] channel_count;
   } cfg_regs_type;

endpackage
`default_nettype wire

@@ rtl/core/bfd_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface bfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_ch0;
   logic [7:0] in_ch1;
   logic [7:0] in_ch2;
   logic [7:0] in_ch3;
   modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
   modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface bfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_ch0;
   logic [7:0]  out_ch1;
   logic [7:0]  out_ch2;
   logic [7:0]  out_ch3;
   logic [11:0] out_col;
   logic [11:0] out_row;
   logic        frame_done;
   modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                   frame_done, input ready);
   modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                 frame_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bfd_lane.sv @@
// One channel lane: column sum store, accumulate and rounding divider.
`timescale 1ns / 1ps
`default_nettype none
module bfd_lane
   import bfd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctl_type       ctl,
   input  wire logic               en,
   input  wire logic [PIX_W-1:0]   pix,
   output      logic [QBITS-1:0]   avg
);
   logic [SUM_W-1:0] mem [MAX_DIM];
   logic [SUM_W-1:0] rd_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QBITS-1:0] q_ff, q_in;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wdata;
   logic [REM_W-1:0] dvs;
   logic [REM_W:0]   trial;

   assign sum   = rd_ff + (en ? {{(SUM_W-PIX_W){1'b0}}, pix_ff} : '0);
   assign wdata = (ctl.acc && !ctl.last) ? sum : '0;
   assign dvs   = {{(REM_W-AREA_W){1'b0}}, ctl.area} << ctl.bit_idx;
   assign trial = {1'b0, rem_ff} - {1'b0, dvs};

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      if (ctl.acc) begin
         rem_in = {1'b0, sum} + {{(REM_W-AREA_W+1){1'b0}}, ctl.area[AREA_W-1:1]};
         q_in   = '0;
      end else if (ctl.div && !trial[REM_W]) begin
         rem_in           = trial[REM_W-1:0];
         q_in[ctl.bit_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[ctl.addr] <= wdata;
      end
      if (ctl.rd) begin
         rd_ff <= mem[ctl.addr];
      end
      if (ctl.take) begin
         pix_ff <= pix;
      end
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign avg = en ? q_ff : '0;
endmodule
`default_nettype wire

@@ rtl/core/bfd_ctrl.sv @@
// Position counters, configuration, block size setup and item sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bfd_ctrl
   import bfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cfg_wr,
   input  wire logic [2:0]   cfg_idx,
   input  wire logic [31:0]  cfg_data,
   input  wire logic         req_valid,
   input  wire logic         out_free,
   output      logic         req_ready,
   output      lane_ctl_type ctl,
   output      out_meta_type meta,
   output      cfg_regs_type regs
);
   cfg_regs_type      regs_ff, regs_in;
   state_type         state_ff, state_in;
   logic [POS_W-1:0]  clr_ff, clr_in;
   logic [SZ_W-1:0]   qx_ff, qx_in, rx_ff, rx_in, qy_ff, qy_in, ry_ff, ry_in;
   logic [SZ_W-1:0]   limx_ff, limx_in, limy_ff, limy_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic              ok_ff, ok_in;
   logic [POS_W-1:0]  scol_ff, scol_in, srow_ff, srow_in, bcol_ff, bcol_in;
   logic [POS_W-1:0]  brow_ff, brow_in, dcol_ff, dcol_in, drow_ff, drow_in;
   logic [POS_W-1:0]  icol_ff, icol_in, irow_ff, irow_in;
   logic              ilast_ff, ilast_in, idone_ff, idone_in;
   logic [QB_W-1:0]   bit_ff, bit_in;
   logic [SZ_W-1:0]   rx_try, ry_try;
   logic [SZ_W:0]     subx, suby;
   logic              col_act, row_act, take, dims_ok;
   logic [2*SZ_W-1:0] prod_x, prod_y, prod_a;

   assign rx_try = {rx_ff[SZ_W-2:0], qx_ff[SZ_W-1]};
   assign ry_try = {ry_ff[SZ_W-2:0], qy_ff[SZ_W-1]};
   assign subx   = {1'b0, rx_try} - {1'b0, regs_ff.dst_width};
   assign suby   = {1'b0, ry_try} - {1'b0, regs_ff.dst_height};
   assign prod_x = qx_ff * regs_ff.dst_width;
   assign prod_y = qy_ff * regs_ff.dst_height;
   assign prod_a = qx_ff * qy_ff;

   assign dims_ok = regs_ff.src_width  != '0 && regs_ff.src_width  <= SZ_W'(MAX_DIM) &&
                    regs_ff.src_height != '0 && regs_ff.src_height <= SZ_W'(MAX_DIM) &&
                    regs_ff.dst_width  != '0 && regs_ff.dst_width  <= SZ_W'(MAX_DIM) &&
                    regs_ff.dst_height != '0 && regs_ff.dst_height <= SZ_W'(MAX_DIM) &&
                    regs_ff.channel_count != '0 &&
                    regs_ff.channel_count <= CC_W'(MAX_CHANNELS);

   assign col_act = {1'b0, scol_ff} < limx_ff;
   assign row_act = {1'b0, srow_ff} < limy_ff;
   assign take    = state_ff == ST_IDLE && req_valid && ok_ff;

   // block sizes, limits and area, worked out during the clearing pass
   always_comb begin
      qx_in = qx_ff; rx_in = rx_ff; qy_in = qy_ff; ry_in = ry_ff;
      limx_in = limx_ff; limy_in = limy_ff; area_in = area_ff; ok_in = ok_ff;
      if (state_ff == ST_CLEAR) begin
         if (clr_ff == '0) begin
            qx_in = regs_ff.src_width;  rx_in = '0;
            qy_in = regs_ff.src_height; ry_in = '0;
            ok_in = 1'b0;
         end else if (clr_ff <= POS_W'(SZ_W)) begin
            qx_in = {qx_ff[SZ_W-2:0], !subx[SZ_W]};
            rx_in = subx[SZ_W] ? rx_try : subx[SZ_W-1:0];
            qy_in = {qy_ff[SZ_W-2:0], !suby[SZ_W]};
            ry_in = suby[SZ_W] ? ry_try : suby[SZ_W-1:0];
         end else if (clr_ff == POS_W'(SZ_W + 1)) begin
            limx_in = prod_x[SZ_W-1:0];
            limy_in = prod_y[SZ_W-1:0];
            area_in = prod_a[AREA_W-1:0];
            ok_in   = dims_ok && qx_ff != '0 && qy_ff != '0;
         end
      end
   end

   // raster position counters
   always_comb begin
      scol_in = scol_ff; srow_in = srow_ff; bcol_in = bcol_ff;
      brow_in = brow_ff; dcol_in = dcol_ff; drow_in = drow_ff;
      if (cfg_wr) begin
         scol_in = '0; srow_in = '0; bcol_in = '0;
         brow_in = '0; dcol_in = '0; drow_in = '0;
      end else if (take) begin
         if (col_act) begin
            if ({1'b0, bcol_ff} + SZ_W'(1) >= qx_ff) begin
               bcol_in = '0;
               dcol_in = dcol_ff + POS_W'(1);
            end else begin
               bcol_in = bcol_ff + POS_W'(1);
            end
         end
         scol_in = scol_ff + POS_W'(1);
         if ({1'b0, scol_ff} + SZ_W'(1) >= regs_ff.src_width) begin
            scol_in = '0; bcol_in = '0; dcol_in = '0;
            if (row_act) begin
               if ({1'b0, brow_ff} + SZ_W'(1) >= qy_ff) begin
                  brow_in = '0;
                  drow_in = drow_ff + POS_W'(1);
               end else begin
                  brow_in = brow_ff + POS_W'(1);
               end
            end
            srow_in = srow_ff + POS_W'(1);
            if ({1'b0, srow_ff} + SZ_W'(1) >= regs_ff.src_height) begin
               srow_in = '0; brow_in = '0; drow_in = '0;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      bit_in   = bit_ff;
      icol_in  = icol_ff; irow_in = irow_ff; ilast_in = ilast_ff; idone_in = idone_ff;
      regs_in  = regs_ff;
      req_ready = 1'b0;
      ctl      = '0;
      ctl.area = area_ff;
      meta.load = 1'b0;
      meta.col  = icol_ff;
      meta.row  = irow_ff;
      meta.done = idone_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.wr   = 1'b1;
            ctl.addr = clr_ff;
            clr_in   = clr_ff + POS_W'(1);
            if (clr_ff == POS_W'(MAX_DIM - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (take && col_act && row_act) begin
               ctl.take = 1'b1;
               ctl.rd   = 1'b1;
               ctl.addr = dcol_ff;
               icol_in  = dcol_ff;
               irow_in  = drow_ff;
               ilast_in = {1'b0, bcol_ff} + SZ_W'(1) == qx_ff &&
                          {1'b0, brow_ff} + SZ_W'(1) == qy_ff;
               idone_in = {1'b0, dcol_ff} + SZ_W'(1) == regs_ff.dst_width &&
                          {1'b0, drow_ff} + SZ_W'(1) == regs_ff.dst_height;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            ctl.acc  = 1'b1;
            ctl.wr   = 1'b1;
            ctl.last = ilast_ff;
            ctl.addr = icol_ff;
            bit_in   = QB_W'(QBITS - 1);
            state_in = ilast_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            ctl.div     = 1'b1;
            ctl.bit_idx = bit_ff;
            bit_in      = bit_ff - QB_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               meta.load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      // any register write restarts the image
      if (cfg_wr) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         case (cfg_idx)
            REG_SRC_WIDTH:  regs_in.src_width     = cfg_data[SZ_W-1:0];
            REG_SRC_HEIGHT: regs_in.src_height    = cfg_data[SZ_W-1:0];
            REG_DST_WIDTH:  regs_in.dst_width     = cfg_data[SZ_W-1:0];
            REG_DST_HEIGHT: regs_in.dst_height    = cfg_data[SZ_W-1:0];
            REG_CHANNELS:   regs_in.channel_count = cfg_data[CC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ok_ff    <= 1'b0;
         regs_ff  <= '{src_width: SZ_W'(1), src_height: SZ_W'(1), dst_width: SZ_W'(1),
                       dst_height: SZ_W'(1), channel_count: CC_W'(MAX_CHANNELS)};
         scol_ff <= '0; srow_ff <= '0; bcol_ff <= '0;
         brow_ff <= '0; dcol_ff <= '0; drow_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ok_ff    <= ok_in;
         regs_ff  <= regs_in;
         scol_ff <= scol_in; srow_ff <= srow_in; bcol_ff <= bcol_in;
         brow_ff <= brow_in; dcol_ff <= dcol_in; drow_ff <= drow_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in; rx_ff <= rx_in; qy_ff <= qy_in; ry_ff <= ry_in;
      limx_ff <= limx_in; limy_ff <= limy_in; area_ff <= area_in;
      bit_ff <= bit_in;
      icol_ff <= icol_in; irow_ff <= irow_in; ilast_ff <= ilast_in; idone_ff <= idone_in;
   end

   assign regs = regs_ff;
endmodule
`default_nettype wire

@@ rtl/core/box_filter_image_downscaler.sv @@
// Top level: configuration port, channel lanes and result register.
//
//  channel   dir  handshake          payload
//  req_if    in   valid/ready        in_ch0..in_ch3
//  rsp_if    out  valid/ready        out_ch0..out_ch3, out_col, out_row, frame_done
//  csr_*     in   APB, pready high   five registers at byte address 4*i
//
// A pixel outside a whole block only advances the position counters. One inside also
// reads and writes back the line store; one that closes a block then runs the 8-step
// rounding divider in all lanes in lockstep, waiting for a free result register. After
// reset or a register write, a clearing pass zeroes the store; no request is taken then.
// A waiting result does not block the next request until another block closes.
`timescale 1ns / 1ps
`default_nettype none
module box_filter_image_downscaler
   import bfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   bfd_req_if.sink          req_if,
   bfd_rsp_if.source        rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   lane_ctl_type     ctl;
   out_meta_type     meta;
   cfg_regs_type     regs;
   logic             cfg_wr;
   logic             out_free;
   logic [PIX_W-1:0] pix [MAX_CHANNELS];
   logic [QBITS-1:0] avg [MAX_CHANNELS];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [QBITS-1:0] ch_ff [MAX_CHANNELS];
   logic [POS_W-1:0] col_ff, row_ff;
   logic             done_ff;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      case (csr_paddr[4:2])
         REG_SRC_WIDTH:  csr_prdata = {{(32-SZ_W){1'b0}}, regs.src_width};
         REG_SRC_HEIGHT: csr_prdata = {{(32-SZ_W){1'b0}}, regs.src_height};
         REG_DST_WIDTH:  csr_prdata = {{(32-SZ_W){1'b0}}, regs.dst_width};
         REG_DST_HEIGHT: csr_prdata = {{(32-SZ_W){1'b0}}, regs.dst_height};
         REG_CHANNELS:   csr_prdata = {{(32-CC_W){1'b0}}, regs.channel_count};
         default:        csr_prdata = '0;
      endcase
   end

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .cfg_idx   (csr_paddr[4:2]),
      .cfg_data  (csr_pwdata),
      .req_valid (req_if.valid),
      .out_free  (out_free),
      .req_ready (req_if.ready),
      .ctl       (ctl),
      .meta      (meta),
      .regs      (regs)
   );

   assign pix[0] = req_if.in_ch0;
   assign pix[1] = req_if.in_ch1;
   assign pix[2] = req_if.in_ch2;
   assign pix[3] = req_if.in_ch3;

   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
      bfd_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .en    (regs.channel_count > CC_W'(i)),
         .pix   (pix[i]),
         .avg   (avg[i])
      );
   end

   // merge lane results into the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (meta.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (meta.load) begin
         ch_ff   <= avg;
         col_ff  <= meta.col;
         row_ff  <= meta.row;
         done_ff <= meta.done;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_ch0    = ch_ff[0];
   assign rsp_if.out_ch1    = ch_ff[1];
   assign rsp_if.out_ch2    = ch_ff[2];
   assign rsp_if.out_ch3    = ch_ff[3];
   assign rsp_if.out_col    = col_ff;
   assign rsp_if.out_row    = row_ff;
   assign rsp_if.frame_done = done_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      meta.load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result register overwritten");

   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_if.ready)
      else $error("request taken during clearing pass");

   a_done_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> ({1'b0, col_ff} + SZ_W'(1) == regs.dst_width))
      else $error("frame end on wrong column");
endmodule
`default_nettype wire
